// ===== hdl/apr_pkg.sv =====
// ----------------------------------------------------------------------------
// apr_pkg: shared types and constants of the average precision ranker
// Item layout, chain cell control, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package apr_pkg;

  // Fixed field widths of the stream payloads and the register
  localparam int unsigned SCORE_W    = 32;
  localparam int unsigned CUTOFF_W   = 11;
  localparam int unsigned AP_W       = 17;
  localparam int unsigned TOTAL_W    = 11;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;

  // Cutoff after reset: no position is cut off
  localparam logic [CUTOFF_W-1:0] CUTOFF_RST = 11'd1024;

  // One ranked entry held by a chain cell
  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      rel;
  } apr_item_t;

  // Chain operation applied to every cell in a cycle
  typedef enum logic [1:0] {
    CHAIN_HOLD,
    CHAIN_INSERT,
    CHAIN_SHIFT
  } chain_op_e;

  // Control broadcast along the chain
  typedef struct packed {
    chain_op_e op;
    apr_item_t item;
  } apr_chain_ctl_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_WALK,
    ST_TERM,
    ST_FINAL,
    ST_DONE
  } apr_state_e;

endpackage

`default_nettype wire

// ===== hdl/apr_cell.sv =====
// ----------------------------------------------------------------------------
// apr_cell: one slot of the sorting chain
// Holds one ranked entry. On insert it keeps its entry, takes the new request
// or takes its left neighbour; on shift it takes its right neighbour.
// ----------------------------------------------------------------------------
`default_nettype none

module apr_cell (
  input  wire                          clk_i,
  input  wire apr_pkg::apr_chain_ctl_t ctl_i,
  input  wire apr_pkg::apr_item_t      left_item_i,
  input  wire                          left_ge_i,
  input  wire apr_pkg::apr_item_t      right_item_i,
  input  wire                          occ_i,
  output apr_pkg::apr_item_t           item_o,
  output logic                         ge_o
);
  import apr_pkg::*;

  apr_item_t item_q;
  apr_item_t item_d;

  // Entry stays ahead of the new request when it scores at least as high
  assign ge_o   = occ_i && (item_q.score >= ctl_i.item.score);
  assign item_o = item_q;

  // Pick the next content of this slot
  always_comb begin
    item_d = item_q;
    case (ctl_i.op)
      CHAIN_INSERT: begin
        if (!ge_o) begin
          item_d = left_ge_i ? ctl_i.item : left_item_i;
        end
      end
      CHAIN_SHIFT: begin
        item_d = right_item_i;
      end
      default: begin
        item_d = item_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

`default_nettype wire

// ===== hdl/apr_div.sv =====
// ----------------------------------------------------------------------------
// apr_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; start_i restarts any division in progress.
// done_o pulses for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module apr_div #(
  parameter int unsigned NUM_W = 28,
  parameter int unsigned DEN_W = 11
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start_i,
  input  wire [NUM_W-1:0]  num_i,
  input  wire [DEN_W-1:0]  den_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  // Bring down the next dividend bit and try the subtraction
  assign rem_sh = {rem_q, quo_q[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      cnt_d = CNT_W'(NUM_W);
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
      quo_d  = {quo_q[NUM_W-2:0], fits};
      rem_d  = fits ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
    end
  end

  // Iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = (cnt_q != '0);
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ===== hdl/average_precision_ranker_top.sv =====
// ----------------------------------------------------------------------------
// average_precision_ranker_top: average precision of one query group
// Requests on the slave stream carry a score and a relevance flag; tlast closes
// the group. Each request is inserted into a chain of MAX_GROUP cells kept in
// descending score order (ties keep arrival order), so a group loads at one
// item per cycle. Requests beyond MAX_GROUP are dropped and flagged. After
// tlast the input stalls while the chain shifts out one rank per cycle; the
// walk pauses while each relevant rank below rank_cutoff runs the shared
// divider, NUM_W = FRAC_BITS + clog2(MAX_GROUP+1) + 1 bits wide (28 by default).
// The final division runs unless there are no hits. The result waits in an
// output register while the receiver stalls, and loading of the next group
// goes on meanwhile. Reset empties the group and sets rank_cutoff to 1024;
// cfg_we_i writes it, and the user must write it only while the block idles;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module average_precision_ranker_top #(
  parameter int unsigned MAX_GROUP = 1024,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // Configuration: rank_cutoff
  input  wire                              cfg_we_i,
  input  wire  [apr_pkg::CUTOFF_W-1:0]     cfg_wdata_i,
  // Input stream
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: [31:0] pred_score, [32] relevant, [39:33] zero
  input  wire  [apr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tlast: group_end
  input  wire                              s_axis_tlast,
  // Result stream
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // tdata: [16:0] avg_precision, [27:17] hit_total, [38:28] item_total,
  //        [39] overflowed
  output logic [apr_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import apr_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_GROUP + 1);
  localparam int unsigned NUM_W = FRAC_BITS + CW + 1;
  localparam int unsigned CMPW  = (CW > CUTOFF_W) ? CW : CUTOFF_W;

  // Registers
  apr_state_e            state_q, state_d;
  logic [CUTOFF_W-1:0]   cutoff_q, cutoff_d;
  logic [CW-1:0]         fill_q, fill_d;
  logic                  drop_q, drop_d;
  logic [CW-1:0]         total_q, total_d;
  logic [CW-1:0]         left_q, left_d;
  logic [CW-1:0]         rank_q, rank_d;
  logic [CW-1:0]         hits_q, hits_d;
  logic [NUM_W-1:0]      sum_q, sum_d;
  logic [NUM_W-1:0]      ap_q, ap_d;
  logic                  out_valid_q, out_valid_d;
  logic [AP_W-1:0]       out_ap_q, out_ap_d;
  logic [TOTAL_W-1:0]    out_hits_q, out_hits_d;
  logic [TOTAL_W-1:0]    out_total_q, out_total_d;
  logic                  out_over_q, out_over_d;

  // Chain and divider signals
  apr_chain_ctl_t        chain_ctl;
  apr_item_t             cell_item [MAX_GROUP];
  logic [MAX_GROUP-1:0]  cell_ge;
  logic                  in_acc;
  logic                  full;
  logic [CW-1:0]         fill_inc;
  logic [CW-1:0]         hits_inc;
  logic                  out_load;
  logic                  div_start;
  logic [NUM_W-1:0]      div_num;
  logic [CW-1:0]         div_den;
  logic                  div_busy;
  logic                  div_done;
  logic [NUM_W-1:0]      div_quo;

  assign s_axis_tready = (state_q == ST_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign full          = (fill_q == CW'(MAX_GROUP));
  assign fill_inc      = fill_q + 1'b1;
  assign hits_inc      = hits_q + 1'b1;

  // Row of sorting cells
  for (genvar k = 0; k < MAX_GROUP; k++) begin : g_cell
    apr_item_t left_item;
    logic      left_ge;
    apr_item_t right_item;
    logic      occ;

    if (k == 0) begin : g_head
      assign left_item = '0;
      assign left_ge   = 1'b1;
    end else begin : g_body
      assign left_item = cell_item[k-1];
      assign left_ge   = cell_ge[k-1];
    end
    if (k == MAX_GROUP - 1) begin : g_tail
      assign right_item = cell_item[k];
    end else begin : g_inner
      assign right_item = cell_item[k+1];
    end
    assign occ = (CW'(k) < fill_q);

    apr_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (chain_ctl),
      .left_item_i  (left_item),
      .left_ge_i    (left_ge),
      .right_item_i (right_item),
      .occ_i        (occ),
      .item_o       (cell_item[k]),
      .ge_o         (cell_ge[k])
    );
  end

  // Shared divider for precision terms and the final mean
  apr_div #(
    .NUM_W (NUM_W),
    .DEN_W (CW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Sequencer: load, walk the ranking, divide, hand over the result
  always_comb begin
    state_d        = state_q;
    cutoff_d       = cfg_we_i ? cfg_wdata_i : cutoff_q;
    fill_d         = fill_q;
    drop_d         = drop_q;
    total_d        = total_q;
    left_d         = left_q;
    rank_d         = rank_q;
    hits_d         = hits_q;
    sum_d          = sum_q;
    ap_d           = ap_q;
    out_load       = 1'b0;
    chain_ctl.op   = CHAIN_HOLD;
    chain_ctl.item.score = $signed(s_axis_tdata[SCORE_W-1:0]);
    chain_ctl.item.rel   = s_axis_tdata[SCORE_W];
    div_start      = 1'b0;
    div_num        = NUM_W'({hits_inc, {FRAC_BITS{1'b0}}});
    div_den        = CW'(rank_q + 1'b1);

    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            chain_ctl.op = CHAIN_INSERT;
            fill_d       = fill_inc;
          end
          if (s_axis_tlast) begin
            total_d = full ? fill_q : fill_inc;
            left_d  = full ? fill_q : fill_inc;
            fill_d  = '0;
            rank_d  = '0;
            hits_d  = '0;
            sum_d   = '0;
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (left_q != '0) begin
          // Retire the rank at the head of the chain
          chain_ctl.op = CHAIN_SHIFT;
          left_d       = left_q - 1'b1;
          rank_d       = rank_q + 1'b1;
          if (cell_item[0].rel) begin
            hits_d = hits_inc;
            if (CMPW'(rank_q) < CMPW'(cutoff_q)) begin
              div_start = 1'b1;
              state_d   = ST_TERM;
            end
          end
        end else if (hits_q == '0) begin
          ap_d    = NUM_W'(1) << FRAC_BITS;
          state_d = ST_DONE;
        end else begin
          div_start = 1'b1;
          div_num   = sum_q + NUM_W'(hits_q >> 1);
          div_den   = hits_q;
          state_d   = ST_FINAL;
        end
      end
      ST_TERM: begin
        if (div_done) begin
          sum_d   = sum_q + div_quo;
          state_d = ST_WALK;
        end
      end
      ST_FINAL: begin
        if (div_done) begin
          ap_d    = div_quo;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          drop_d   = 1'b0;
          state_d  = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    out_ap_d    = out_ap_q;
    out_hits_d  = out_hits_q;
    out_total_d = out_total_q;
    out_over_d  = out_over_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_ap_d    = AP_W'(ap_q);
      out_hits_d  = TOTAL_W'(hits_q);
      out_total_d = TOTAL_W'(total_q);
      out_over_d  = drop_q;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cutoff_q    <= CUTOFF_RST;
      fill_q      <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cutoff_q    <= cutoff_d;
      fill_q      <= fill_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Walk counters and result payload
  always_ff @(posedge clk_i) begin
    total_q     <= total_d;
    left_q      <= left_d;
    rank_q      <= rank_d;
    hits_q      <= hits_d;
    sum_q       <= sum_d;
    ap_q        <= ap_d;
    out_ap_q    <= out_ap_d;
    out_hits_q  <= out_hits_d;
    out_total_q <= out_total_d;
    out_over_q  <= out_over_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_over_q, out_total_q, out_hits_q, out_ap_q};

  // Checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(MAX_GROUP))
    else $error("fill count beyond chain length");

  a_stall_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast) |=> !s_axis_tready)
    else $error("input taken after the group end");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_hits_le_items: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (hits_q <= total_q))
    else $error("more hits than ranked items");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && drop_q) |-> (total_q == CW'(MAX_GROUP)))
    else $error("drop flagged on a group below capacity");

endmodule

`default_nettype wire
